@@ src/face_box_percent_dedup_defines.svh @@
// ----------------------------------------------------------------------------
// face_box_percent_dedup_defines.svh
// Assertion macros for the face box dedup RTL.
// ----------------------------------------------------------------------------
`ifndef FACE_BOX_PERCENT_DEDUP_DEFINES_SVH
`define FACE_BOX_PERCENT_DEDUP_DEFINES_SVH

`ifndef SYNTH

// Condition holds at every clock edge out of reset.
`define FBPD_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define FBPD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FBPD_ALWAYS(lbl, cond, msg)
`define FBPD_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/fbpd_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpd_pkg
// Widths, codes and types shared by the face box dedup block.
// ----------------------------------------------------------------------------
package fbpd_pkg;

    localparam int DIM_W      = 14;
    localparam int PCT_W      = 16;
    localparam int NUM_W      = DIM_W + PCT_W;
    localparam int TENTH_W    = 19;
    localparam int EDGE_N     = 4;
    localparam int MAX_KEPT   = 16;
    localparam int IDX_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W      = $clog2(MAX_KEPT + 1);
    localparam int STEP_W     = $clog2(PCT_W + 1);
    localparam int DUP_TOL    = 512;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_W       = 4 * DIM_W;
    localparam int OUT_W      = EDGE_N * PCT_W;
    localparam int STATUS_W   = 2;

    // Edge slots inside one box
    localparam int E_LEFT   = 0;
    localparam int E_TOP    = 1;
    localparam int E_RIGHT  = 2;
    localparam int E_BOTTOM = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW  = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } t_status;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_SCAN,
        S_CMP,
        S_FINISH
    } t_state;

    typedef logic [EDGE_N-1:0][PCT_W-1:0] t_box;

endpackage

@@ src/fbpd_divider.sv @@
// ----------------------------------------------------------------------------
// fbpd_divider
// Restoring divider, one quotient bit per cycle, saturating at all ones.
// ----------------------------------------------------------------------------
module fbpd_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [fbpd_pkg::NUM_W-1:0] i_num,
    input  logic [fbpd_pkg::DIM_W-1:0] i_den,
    output logic                     o_done,
    output logic [fbpd_pkg::PCT_W-1:0] o_quot
);
    import fbpd_pkg::*;

    logic              r_active;
    logic              r_done;
    logic              r_sat;
    logic [STEP_W-1:0] r_cnt;
    logic [DIM_W-1:0]  r_rem;
    logic [PCT_W-1:0]  r_low;
    logic [PCT_W-1:0]  r_quot;
    logic [DIM_W-1:0]  r_den;

    logic [DIM_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DIM_W:0]    w_rem_sub;

    assign w_rem_sh  = {r_rem, r_low[PCT_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= STEP_W'(PCT_W);
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // datapath: the high part below the divisor means the quotient fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= (i_num[NUM_W-1:PCT_W] >= i_den);
            r_rem  <= i_num[NUM_W-1:PCT_W];
            r_low  <= i_num[PCT_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_active) begin
            r_rem  <= w_ge ? w_rem_sub[DIM_W-1:0] : w_rem_sh[DIM_W-1:0];
            r_low  <= {r_low[PCT_W-2:0], 1'b0};
            r_quot <= {r_quot[PCT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? '1 : r_quot;

endmodule

@@ src/face_box_percent_dedup.sv @@
// ----------------------------------------------------------------------------
// face_box_percent_dedup
// Face box shrink, percent conversion and per-frame duplicate filter.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata box, tlast batch end
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata box edges, tuser status
//  cfg      | in  | i_cfg_valid / o_cfg_ready     | i_cfg_addr, i_cfg_data
//
//  One box at a time. A box passes from its input beat through a load state,
//  the four parallel bit-serial dividers, a registered read of the box memory
//  and a compare per kept box, and a finish state to its result; a full table
//  takes longest and an early duplicate hit ends the scan sooner. A zero frame
//  size skips the divide and the scan.
//  Reset clears the box count and the frame size; the box memory needs no
//  clearing since only entries below the count are read.
//  The result sits in an output register; the next box is accepted while it
//  waits, and a box only stalls in its final state if the previous result is
//  still held.
//
// ----------------------------------------------------------------------------
`include "face_box_percent_dedup_defines.svh"

module face_box_percent_dedup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // box_x, box_y, box_width, box_height (from bit 0 up)
    input  logic [fbpd_pkg::IN_W-1:0]         s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // left_pct, top_pct, right_pct, bottom_pct (from bit 0 up)
    output logic [fbpd_pkg::OUT_W-1:0]        m_axis_tdata,
    // status
    output logic [fbpd_pkg::STATUS_W-1:0]     m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbpd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fbpd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fbpd_pkg::*;

    // Numerator of one edge: (10*base + k*size) * 2560, k = 1 near, 9 far
    function automatic logic [NUM_W-1:0] pct_num(input logic [DIM_W-1:0] base,
                                                 input logic [DIM_W-1:0] size,
                                                 input logic             far);
        logic [TENTH_W-1:0] b10;
        logic [TENTH_W-1:0] s_k;
        logic [TENTH_W-1:0] t;
        b10 = (TENTH_W'(base) << 3) + (TENTH_W'(base) << 1);
        s_k = far ? (TENTH_W'(size) << 3) + TENTH_W'(size) : TENTH_W'(size);
        t   = b10 + s_k;
        return (NUM_W'(t) << 11) + (NUM_W'(t) << 9);
    endfunction

    // Every edge within tolerance of the kept box
    function automatic logic box_near(input t_box a, input t_box b);
        logic            ok;
        logic [PCT_W-1:0] d;
        ok = 1'b1;
        for (int e = 0; e < EDGE_N; e++) begin
            d = (a[e] > b[e]) ? a[e] - b[e] : b[e] - a[e];
            if (d > PCT_W'(DUP_TOL)) ok = 1'b0;
        end
        return ok;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: ready out of reset, bad indexes are dropped
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_fw;
    logic [DIM_W-1:0] r_fh;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= '0;
            r_fh <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_addr == REG_FRAME_WIDTH)  r_fw <= i_cfg_data[DIM_W-1:0];
            if (i_cfg_addr == REG_FRAME_HEIGHT) r_fh <= i_cfg_data[DIM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic             r_zero;
    logic             r_dup;
    logic [NUM_W-1:0] r_num [EDGE_N];
    t_box             r_pct;
    t_box             r_rd_data;
    t_box             r_kept_mem [MAX_KEPT];
    logic             r_out_valid;
    t_box             r_out_box;
    t_status          r_out_status;

    logic             w_in_beat;
    logic             w_div_start;
    logic             w_rd_en;
    logic             w_fin;
    logic             w_mem_we;
    logic             w_near;
    logic             w_scan_end;
    logic             w_all_done;
    logic [EDGE_N-1:0] w_div_done;
    t_box             w_quot;
    t_status          w_status;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_all_done = &w_div_done;
    assign w_near     = box_near(r_rd_data, r_pct);
    assign w_scan_end = ((CNT_W'(r_idx) + 1'b1) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_beat) n_state = S_LOAD;
            S_LOAD:   n_state = r_zero ? S_FINISH : S_DIV;
            S_DIV:    if (w_all_done) n_state = (r_count == '0) ? S_FINISH : S_SCAN;
            S_SCAN:   n_state = S_CMP;
            S_CMP:    n_state = (w_near || w_scan_end) ? S_FINISH : S_SCAN;
            S_FINISH: if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer; hold the input off while in reset
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_rd_en       = 1'b0;
        w_fin         = 1'b0;
        unique case (r_state)
            S_IDLE:   s_axis_tready = i_rst_n;
            S_LOAD:   w_div_start   = !r_zero;
            S_SCAN:   w_rd_en       = 1'b1;
            S_FINISH: w_fin         = !r_out_valid || m_axis_tready;
            default:  ;
        endcase
    end

    // classify the box once the scan is over
    always_comb begin
        if (r_zero)                             w_status = ST_ZERO;
        else if (r_dup)                         w_status = ST_DUP;
        else if (r_count >= CNT_W'(MAX_KEPT))   w_status = ST_FULL;
        else                                    w_status = ST_NEW;
    end

    assign w_mem_we = w_fin && (w_status == ST_NEW);

    // box count: bump on store, drop to zero after the last box of a frame
    always_comb begin
        n_count = r_count;
        if (w_fin) begin
            if (r_last)        n_count = '0;
            else if (w_mem_we) n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fin)              r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Box datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            for (int e = 0; e < EDGE_N; e++) begin
                r_num[e] <= pct_num(s_axis_tdata[(e % 2) * DIM_W +: DIM_W],
                                    s_axis_tdata[(2 + e % 2) * DIM_W +: DIM_W],
                                    e >= 2);
            end
            r_last <= s_axis_tlast;
            r_zero <= (r_fw == '0) || (r_fh == '0);
            r_dup  <= 1'b0;
            r_idx  <= '0;
            r_pct  <= '0;
        end else begin
            if (r_state == S_DIV && w_all_done) r_pct <= w_quot;
            if (r_state == S_CMP) begin
                if (w_near) r_dup <= 1'b1;
                else        r_idx <= r_idx + 1'b1;
            end
        end
    end

    // four dividers, one per edge, run side by side
    for (genvar g = 0; g < EDGE_N; g++) begin : g_div
        fbpd_divider u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_div_start),
            .i_num   (r_num[g]),
            .i_den   ((g % 2 == 0) ? r_fw : r_fh),
            .o_done  (w_div_done[g]),
            .o_quot  (w_quot[g])
        );
    end

    // kept box memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_kept_mem[r_count[IDX_W-1:0]] <= r_pct;
        if (w_rd_en)  r_rd_data <= r_kept_mem[r_idx];
    end

    // output register: load on finish, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_box    <= r_pct;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_box;
    assign m_axis_tuser  = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FBPD_ALWAYS(a_count_bound, r_count <= CNT_W'(MAX_KEPT), "box count above table depth")
    `FBPD_ALWAYS(a_store_room, !w_mem_we || (r_count < CNT_W'(MAX_KEPT)), "store into full table")
    `FBPD_NEXT(a_fin_valid, w_fin, m_axis_tvalid, "finished box produced no result")
    `FBPD_NEXT(a_in_to_load, w_in_beat, r_state == S_LOAD, "accepted box did not start")
    `FBPD_ALWAYS(a_scan_in_range, !(r_state == S_SCAN) || (CNT_W'(r_idx) < r_count),
                 "scan beyond kept boxes")

endmodule
